// ===== src/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// rna_pkg
// Shared opcodes, command and status types for the rational number alu.
// ----------------------------------------------------------------------------
package rna_pkg;

   // request opcodes
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_POW = 4'd4;
   localparam logic [3:0] OP_RED = 4'd5;
   localparam logic [3:0] OP_EQ  = 4'd6;
   localparam logic [3:0] OP_LT  = 4'd7;
   localparam logic [3:0] OP_LE  = 4'd8;
   localparam logic [3:0] OP_GT  = 4'd9;
   localparam logic [3:0] OP_GE  = 4'd10;

   // datapath actions
   typedef enum logic [3:0] {
      DP_NONE, DP_LOAD, DP_NEG_BN, DP_MUL, DP_ADD, DP_COPY_A, DP_GCD,
      DP_DIV_NUM, DP_DIV_DEN, DP_SIGN, DP_POW_INIT, DP_POW_STEP,
      DP_POW_NUM_END, DP_POW_DEN_END, DP_CMP, DP_OUT
   } dp_op_type;

   // multiplier operand sources
   typedef enum logic [2:0] {
      SRC_AN, SRC_AD, SRC_BN, SRC_BD, SRC_RN, SRC_RD, SRC_ACC
   } src_type;

   // iterative unit destinations
   typedef enum logic [1:0] {DST_RN, DST_RD, DST_TMP, DST_ACC} dst_type;

   // iterative unit modes
   typedef enum logic [1:0] {U_MUL, U_DIV, U_GCD} unit_type;

   typedef struct packed {
      dp_op_type op;
      src_type   src_a;
      src_type   src_b;
      dst_type   dst;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic       rd_zero;
      logic       ecnt_zero;
      logic       out_free;
      logic [3:0] opcode;
   } stat_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_NEGB, ST_MUL1, ST_MUL2, ST_ADD, ST_MULD, ST_MULN,
      ST_DIVN, ST_DIVD, ST_CMP1, ST_CMP2, ST_CMP, ST_COPY, ST_RED, ST_QN, ST_QD,
      ST_SIGN, ST_PINIT, ST_PN, ST_PD, ST_WAIT, ST_OUT
   } ctrl_state_type;

endpackage

// ===== src/rna_req_if.sv =====
// ----------------------------------------------------------------------------
// rna_req_if
// Request channel: opcode, two fractions and an exponent.
// ----------------------------------------------------------------------------
interface rna_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         opcode;
   logic signed [63:0] a_num;
   logic signed [63:0] a_den;
   logic signed [63:0] b_num;
   logic signed [63:0] b_den;
   logic [5:0]         exponent;

   modport source (output valid, opcode, a_num, a_den, b_num, b_den, exponent,
                   input ready);
   modport sink (input valid, opcode, a_num, a_den, b_num, b_den, exponent,
                 output ready);
endinterface

// ===== src/rna_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rna_rsp_if
// Response channel: result fraction, comparison bit and overflow bit.
// ----------------------------------------------------------------------------
interface rna_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] res_num;
   logic signed [63:0] res_den;
   logic               truth;
   logic               overflow;

   modport source (output valid, res_num, res_den, truth, overflow, input ready);
   modport sink (input valid, res_num, res_den, truth, overflow, output ready);
endinterface

// ===== src/rna_ctrl.sv =====
// ----------------------------------------------------------------------------
// rna_ctrl
// Sequencer that steps the datapath through each operation.
// ----------------------------------------------------------------------------
module rna_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rna_pkg::stat_type stat,
   output rna_pkg::cmd_type  cmd
);
   import rna_pkg::*;

   ctrl_state_type state_ff, state_in;
   ctrl_state_type ret_ff, ret_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      req_ready = 1'b0;
      cmd       = '{op: DP_NONE, src_a: SRC_AN, src_b: SRC_AN, dst: DST_RN};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.opcode)
               OP_ADD: state_in = ST_MUL1;
               OP_SUB: state_in = ST_NEGB;
               OP_MUL: state_in = ST_MULN;
               OP_DIV: state_in = ST_DIVN;
               OP_POW: state_in = ST_COPY;
               OP_RED: state_in = ST_COPY;
               OP_EQ:  state_in = ST_CMP1;
               OP_LT:  state_in = ST_CMP1;
               OP_LE:  state_in = ST_CMP1;
               OP_GT:  state_in = ST_CMP1;
               OP_GE:  state_in = ST_CMP1;
               default: state_in = ST_OUT;
            endcase
         end
         ST_NEGB: begin
            cmd.op   = DP_NEG_BN;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd = '{op: DP_MUL, src_a: SRC_AN, src_b: SRC_BD, dst: DST_TMP};
            ret_in = ST_MUL2;
            state_in = ST_WAIT;
         end
         ST_MUL2: begin
            cmd = '{op: DP_MUL, src_a: SRC_AD, src_b: SRC_BN, dst: DST_RN};
            ret_in = ST_ADD;
            state_in = ST_WAIT;
         end
         ST_ADD: begin
            cmd.op   = DP_ADD;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            cmd = '{op: DP_MUL, src_a: SRC_AD, src_b: SRC_BD, dst: DST_RD};
            ret_in = ST_RED;
            state_in = ST_WAIT;
         end
         ST_MULN: begin
            cmd = '{op: DP_MUL, src_a: SRC_AN, src_b: SRC_BN, dst: DST_RN};
            ret_in = ST_MULD;
            state_in = ST_WAIT;
         end
         ST_DIVN: begin
            cmd = '{op: DP_MUL, src_a: SRC_AN, src_b: SRC_BD, dst: DST_RN};
            ret_in = ST_DIVD;
            state_in = ST_WAIT;
         end
         ST_DIVD: begin
            cmd = '{op: DP_MUL, src_a: SRC_AD, src_b: SRC_BN, dst: DST_RD};
            ret_in = ST_RED;
            state_in = ST_WAIT;
         end
         ST_CMP1: begin
            cmd = '{op: DP_MUL, src_a: SRC_AN, src_b: SRC_BD, dst: DST_TMP};
            ret_in = ST_CMP2;
            state_in = ST_WAIT;
         end
         ST_CMP2: begin
            cmd = '{op: DP_MUL, src_a: SRC_AD, src_b: SRC_BN, dst: DST_RN};
            ret_in = ST_CMP;
            state_in = ST_WAIT;
         end
         ST_CMP: begin
            cmd.op   = DP_CMP;
            state_in = ST_OUT;
         end
         ST_COPY: begin
            cmd.op   = DP_COPY_A;
            state_in = ST_RED;
         end
         // gcd only when the denominator is nonzero
         ST_RED: begin
            if (stat.rd_zero) begin
               state_in = ST_SIGN;
            end else begin
               cmd.op   = DP_GCD;
               ret_in   = ST_QN;
               state_in = ST_WAIT;
            end
         end
         ST_QN: begin
            cmd.op   = DP_DIV_NUM;
            ret_in   = ST_QD;
            state_in = ST_WAIT;
         end
         ST_QD: begin
            cmd.op   = DP_DIV_DEN;
            ret_in   = ST_SIGN;
            state_in = ST_WAIT;
         end
         ST_SIGN: begin
            cmd.op   = DP_SIGN;
            state_in = (stat.opcode == OP_POW) ? ST_PINIT : ST_OUT;
         end
         ST_PINIT: begin
            cmd.op   = DP_POW_INIT;
            state_in = ST_PN;
         end
         // raise numerator, then denominator
         ST_PN: begin
            if (stat.ecnt_zero) begin
               cmd.op   = DP_POW_NUM_END;
               state_in = ST_PD;
            end else begin
               cmd = '{op: DP_POW_STEP, src_a: SRC_ACC, src_b: SRC_RN, dst: DST_ACC};
               ret_in   = ST_PN;
               state_in = ST_WAIT;
            end
         end
         ST_PD: begin
            if (stat.ecnt_zero) begin
               cmd.op   = DP_POW_DEN_END;
               state_in = ST_OUT;
            end else begin
               cmd = '{op: DP_POW_STEP, src_a: SRC_ACC, src_b: SRC_RD, dst: DST_ACC};
               ret_in   = ST_PD;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!stat.busy) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.op   = DP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/rna_dp.sv =====
// ----------------------------------------------------------------------------
// rna_dp
// Operand registers, bit-serial multiply/divide/binary gcd unit and the
// response register.
// ----------------------------------------------------------------------------
module rna_dp #(
   parameter int WORD_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  rna_pkg::cmd_type   cmd,
   output rna_pkg::stat_type  stat,
   input  logic [3:0]         req_opcode,
   input  logic [63:0]        req_a_num,
   input  logic [63:0]        req_a_den,
   input  logic [63:0]        req_b_num,
   input  logic [63:0]        req_b_den,
   input  logic [5:0]         req_exponent,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [63:0]        rsp_res_num,
   output logic [63:0]        rsp_res_den,
   output logic               rsp_truth,
   output logic               rsp_overflow
);
   import rna_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(WORD_BITS + 1);
   localparam logic [W-1:0] SBIT = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1};

   logic [W-1:0]   an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic [W-1:0]   rn_ff, rd_ff, tmp_ff, acc_ff, rn_in, rd_in, tmp_in, acc_in;
   logic [3:0]     op_ff, op_in;
   logic [5:0]     exp_ff, exp_in, ecnt_ff, ecnt_in;
   logic           ov_ff, ov_in, truth_ff, truth_in;
   unit_type       mode_ff, mode_in;
   logic           busy_ff, busy_in;
   logic [CW-1:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic [2*W-1:0] p_ff, p_in;
   logic [W-1:0]   ma_ff, ma_in;
   logic           neg_ff, neg_in;
   dst_type        dst_ff, dst_in;
   logic           out_valid_ff, out_valid_in;
   logic [63:0]    out_num_ff, out_num_in, out_den_ff, out_den_in;
   logic           out_truth_ff, out_truth_in, out_ov_ff, out_ov_in;

   function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
      return v[W-1] ? (~v + ONE) : v;
   endfunction

   function automatic logic [W-1:0] sel_f(input src_type s, input logic [W-1:0] an,
                                          input logic [W-1:0] ad, input logic [W-1:0] bn,
                                          input logic [W-1:0] bd, input logic [W-1:0] rn,
                                          input logic [W-1:0] rd, input logic [W-1:0] acc);
      logic [W-1:0] r;
      case (s)
         SRC_AN:  r = an;
         SRC_AD:  r = ad;
         SRC_BN:  r = bn;
         SRC_BD:  r = bd;
         SRC_RN:  r = rn;
         SRC_RD:  r = rd;
         SRC_ACC: r = acc;
         default: r = '0;
      endcase
      return r;
   endfunction

   // status toward the sequencer
   assign stat.busy      = busy_ff;
   assign stat.rd_zero   = (rd_ff == '0);
   assign stat.ecnt_zero = (ecnt_ff == 6'd0);
   assign stat.out_free  = !out_valid_ff || rsp_ready;
   assign stat.opcode    = op_ff;

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_num  = out_num_ff;
   assign rsp_res_den  = out_den_ff;
   assign rsp_truth    = out_truth_ff;
   assign rsp_overflow = out_ov_ff;

   // next values
   always_comb begin
      logic [W-1:0] a_v, b_v, res, u, v, lim, s;
      logic [W:0]   sum, r_sh, diff;
      logic         wr;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      rn_in = rn_ff; rd_in = rd_ff; tmp_in = tmp_ff; acc_in = acc_ff;
      op_in = op_ff; exp_in = exp_ff; ecnt_in = ecnt_ff;
      ov_in = ov_ff; truth_in = truth_ff;
      mode_in = mode_ff; busy_in = busy_ff; cnt_in = cnt_ff; k_in = k_ff;
      p_in = p_ff; ma_in = ma_ff; neg_in = neg_ff; dst_in = dst_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_num_in = out_num_ff; out_den_in = out_den_ff;
      out_truth_in = out_truth_ff; out_ov_in = out_ov_ff;
      a_v = '0; b_v = '0; res = '0; lim = '0; s = '0;
      sum = '0; r_sh = '0; diff = '0; wr = 1'b0;
      u = p_ff[2*W-1:W];
      v = p_ff[W-1:0];

      // iterative unit
      if (busy_ff) begin
         case (mode_ff)
            U_MUL: begin
               if (cnt_ff == CW'(W)) begin
                  lim = neg_ff ? SBIT : (SBIT - ONE);
                  if ((p_ff[2*W-1:W] != '0) || (p_ff[W-1:0] > lim)) ov_in = 1'b1;
                  res = neg_ff ? (~p_ff[W-1:0] + ONE) : p_ff[W-1:0];
                  wr = 1'b1;
               end else begin
                  sum = {1'b0, p_ff[2*W-1:W]} + (p_ff[0] ? {1'b0, ma_ff} : '0);
                  p_in = {sum, p_ff[W-1:1]};
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            U_DIV: begin
               if (cnt_ff == CW'(W)) begin
                  res = neg_ff ? (~p_ff[W-1:0] + ONE) : p_ff[W-1:0];
                  wr = 1'b1;
               end else begin
                  r_sh = {p_ff[2*W-1:W], p_ff[W-1]};
                  if (r_sh >= {1'b0, ma_ff}) begin
                     diff = r_sh - {1'b0, ma_ff};
                     p_in = {diff[W-1:0], p_ff[W-2:0], 1'b1};
                  end else begin
                     p_in = {r_sh[W-1:0], p_ff[W-2:0], 1'b0};
                  end
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            U_GCD: begin
               if ((u == '0) || (v == '0)) begin
                  tmp_in = (u | v) << k_ff;
                  busy_in = 1'b0;
               end else if (!u[0] && !v[0]) begin
                  p_in = {u >> 1, v >> 1};
                  k_in = k_ff + CW'(1);
               end else if (!u[0]) begin
                  p_in = {u >> 1, v};
               end else if (!v[0]) begin
                  p_in = {u, v >> 1};
               end else if (u >= v) begin
                  p_in = {u - v, v};
               end else begin
                  p_in = {u, v - u};
               end
            end
            default: busy_in = 1'b0;
         endcase
         // write back a finished product or quotient
         if (wr) begin
            busy_in = 1'b0;
            case (dst_ff)
               DST_RN:  rn_in = res;
               DST_RD:  rd_in = res;
               DST_TMP: tmp_in = res;
               DST_ACC: acc_in = res;
               default: ;
            endcase
         end
      end

      // sequencer commands
      case (cmd.op)
         DP_LOAD: begin
            an_in = req_a_num[W-1:0];
            ad_in = req_a_den[W-1:0];
            bn_in = req_b_num[W-1:0];
            bd_in = req_b_den[W-1:0];
            op_in = req_opcode;
            exp_in = req_exponent;
            rn_in = '0; rd_in = '0;
            ov_in = 1'b0; truth_in = 1'b0;
         end
         DP_NEG_BN: begin
            if (bn_ff == SBIT) ov_in = 1'b1;
            bn_in = ~bn_ff + ONE;
         end
         DP_MUL, DP_POW_STEP: begin
            a_v = sel_f(cmd.src_a, an_ff, ad_ff, bn_ff, bd_ff, rn_ff, rd_ff, acc_ff);
            b_v = sel_f(cmd.src_b, an_ff, ad_ff, bn_ff, bd_ff, rn_ff, rd_ff, acc_ff);
            ma_in = mag_f(a_v);
            p_in = {{W{1'b0}}, mag_f(b_v)};
            neg_in = a_v[W-1] ^ b_v[W-1];
            dst_in = cmd.dst;
            mode_in = U_MUL; busy_in = 1'b1; cnt_in = '0;
            if (cmd.op == DP_POW_STEP) ecnt_in = ecnt_ff - 6'd1;
         end
         DP_ADD: begin
            s = tmp_ff + rn_ff;
            if ((tmp_ff[W-1] == rn_ff[W-1]) && (s[W-1] != tmp_ff[W-1])) ov_in = 1'b1;
            rn_in = s;
         end
         DP_COPY_A: begin
            rn_in = an_ff; rd_in = ad_ff;
         end
         DP_GCD: begin
            p_in = {mag_f(rn_ff), mag_f(rd_ff)};
            k_in = '0; mode_in = U_GCD; busy_in = 1'b1;
         end
         DP_DIV_NUM: begin
            p_in = {{W{1'b0}}, mag_f(rn_ff)};
            ma_in = tmp_ff; neg_in = rn_ff[W-1]; dst_in = DST_RN;
            mode_in = U_DIV; busy_in = 1'b1; cnt_in = '0;
         end
         DP_DIV_DEN: begin
            p_in = {{W{1'b0}}, mag_f(rd_ff)};
            ma_in = tmp_ff; neg_in = rd_ff[W-1]; dst_in = DST_RD;
            mode_in = U_DIV; busy_in = 1'b1; cnt_in = '0;
         end
         // move a negative denominator's sign to the numerator
         DP_SIGN: begin
            if (rd_ff[W-1]) begin
               if ((rn_ff == SBIT) || (rd_ff == SBIT)) ov_in = 1'b1;
               rn_in = ~rn_ff + ONE;
               rd_in = ~rd_ff + ONE;
            end
         end
         DP_POW_INIT: begin
            acc_in = ONE; ecnt_in = exp_ff;
         end
         DP_POW_NUM_END: begin
            rn_in = acc_ff; acc_in = ONE; ecnt_in = exp_ff;
         end
         DP_POW_DEN_END: rd_in = acc_ff;
         // cross-multiplied compare: tmp holds a.num*b.den, rn holds a.den*b.num
         DP_CMP: begin
            case (op_ff)
               OP_EQ:   truth_in = (tmp_ff == rn_ff);
               OP_LT:   truth_in = ($signed(tmp_ff) < $signed(rn_ff));
               OP_LE:   truth_in = !($signed(rn_ff) < $signed(tmp_ff));
               OP_GT:   truth_in = ($signed(rn_ff) < $signed(tmp_ff));
               OP_GE:   truth_in = !($signed(tmp_ff) < $signed(rn_ff));
               default: truth_in = 1'b0;
            endcase
            rn_in = '0; rd_in = '0;
         end
         DP_OUT: begin
            out_valid_in = 1'b1;
            out_num_in = 64'($signed(rn_ff));
            out_den_in = 64'($signed(rd_ff));
            out_truth_in = truth_ff;
            out_ov_in = ov_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      rn_ff <= rn_in; rd_ff <= rd_in; tmp_ff <= tmp_in; acc_ff <= acc_in;
      op_ff <= op_in; exp_ff <= exp_in; ecnt_ff <= ecnt_in;
      ov_ff <= ov_in; truth_ff <= truth_in;
      mode_ff <= mode_in; cnt_ff <= cnt_in; k_ff <= k_in;
      p_ff <= p_in; ma_ff <= ma_in; neg_ff <= neg_in; dst_ff <= dst_in;
      out_num_ff <= out_num_in; out_den_ff <= out_den_in;
      out_truth_ff <= out_truth_in; out_ov_ff <= out_ov_in;
   end

   // checks
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(cmd.op == DP_MUL || cmd.op == DP_POW_STEP || cmd.op == DP_GCD ||
                    cmd.op == DP_DIV_NUM || cmd.op == DP_DIV_DEN))
      else $error("iterative unit restarted while busy");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_OUT |-> (!out_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && mode_ff != U_GCD) |-> cnt_ff <= CW'(W))
      else $error("bit counter ran past word width");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_LOAD |=> (!ov_ff && !truth_ff && !busy_ff))
      else $error("flags not cleared on new request");

endmodule

// ===== src/rational_number_alu.sv =====
// ----------------------------------------------------------------------------
// rational_number_alu
// Fraction arithmetic and comparison with gcd reduction.
// ----------------------------------------------------------------------------
// One request at a time. Every product goes through a shared bit-serial
// multiplier; reduction runs a binary gcd and two bit-serial divisions when
// the denominator is nonzero; pow adds 2*exponent multiplies.
// A finished response sits in an output register, so the next request is
// taken while the previous response waits.
module rational_number_alu #(
   parameter int WORD_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   rna_req_if.sink    req_chan,
   rna_rsp_if.source  rsp_chan
);
   import rna_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   // sequencer
   rna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   rna_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_chan.opcode),
      .req_a_num    (req_chan.a_num),
      .req_a_den    (req_chan.a_den),
      .req_b_num    (req_chan.b_num),
      .req_b_den    (req_chan.b_den),
      .req_exponent (req_chan.exponent),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_res_num  (rsp_chan.res_num),
      .rsp_res_den  (rsp_chan.res_den),
      .rsp_truth    (rsp_chan.truth),
      .rsp_overflow (rsp_chan.overflow)
   );

endmodule

// ===== sim/rational_number_alu_test.sv =====
// ----------------------------------------------------------------------------
// rational_number_alu_test
// Self-checking bench for the rational number alu. A directed table covers
// extremes, every opcode and the corner cases of reduction and sign handling.
// Random requests follow, under three idle mixes, a long response hold-off
// and a drain pause. Every response is checked against a table value or a built-in predictor.
// ----------------------------------------------------------------------------
module rational_number_alu_test;
   import rna_pkg::*;

   localparam logic [3:0]  OP_UNUSED  = 4'd15;
   localparam logic [3:0]  OP_SPARE   = 4'd11;
   localparam logic [63:0] MIN_WORD   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_WORD   = 64'h7fff_ffff_ffff_ffff;
   localparam int          IDLE_LIMIT = 100000;
   localparam int          HOLD_LEN   = 2000;
   localparam int          N_RANDOM   = 1000;

   typedef struct {
      logic [3:0]  opcode;
      logic [63:0] a_num, a_den, b_num, b_den;
      logic [5:0]  exponent;
   } frac_req_type;

   typedef struct {
      logic [63:0] num, den;
      logic        truth, overflow;
   } frac_rsp_type;

   typedef struct {
      frac_req_type req;
      bit           typed;
      frac_rsp_type rsp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rna_req_if req_bus();
   rna_rsp_if rsp_bus();

   rational_number_alu i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #6 clock = ~clock;

   frac_rsp_type pending_rsp[$];
   int           mismatches  = 0;
   int           send_idle   = 0;
   int           recv_idle   = 0;
   bit           hold_req    = 1'b0;
   int           quiet_count = 0;

   // ------------------------------------------------------------ predictor
   function automatic logic [63:0] mag_of(input logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] neg_wrap(input logic [63:0] v, inout logic ov);
      if (v == MIN_WORD) ov = 1'b1;
      return -v;
   endfunction

   function automatic logic [63:0] add_wrap(input logic [63:0] a, b, inout logic ov);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) ov = 1'b1;
      return r;
   endfunction

   function automatic logic [63:0] mul_wrap(input logic [63:0] a, b, inout logic ov);
      logic [63:0] ma, mb, lim;
      ma  = mag_of(a);
      mb  = mag_of(b);
      lim = (a[63] != b[63]) ? MIN_WORD : MAX_WORD;
      if (ma != 0 && mb > lim / ma) ov = 1'b1;
      return a * b;
   endfunction

   function automatic logic [63:0] gcd_of(input logic [63:0] x, y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void reduce_frac(inout logic [63:0] n, d, inout logic ov);
      logic [63:0] g, qn, qd;
      if (d != 0) begin
         g = gcd_of(mag_of(n), mag_of(d));
         if (g != 0) begin
            qn = mag_of(n) / g;
            qd = mag_of(d) / g;
            n  = n[63] ? -qn : qn;
            d  = d[63] ? -qd : qd;
         end
      end
      // sign moves to the numerator
      if (d[63]) begin
         n = neg_wrap(n, ov);
         d = neg_wrap(d, ov);
      end
   endfunction

   function automatic logic [63:0] pow_wrap(input logic [63:0] base, input logic [5:0] e,
                                            inout logic ov);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < e; i++) r = mul_wrap(r, base, ov);
      return r;
   endfunction

   function automatic bit less_s(input logic [63:0] x, y);
      return $signed(x) < $signed(y);
   endfunction

   function automatic frac_rsp_type predict_frac(input frac_req_type q);
      frac_rsp_type r;
      logic [63:0]  bn, lhs, rhs, n, d;
      logic         ov;
      r  = '{num: 0, den: 0, truth: 0, overflow: 0};
      ov = 1'b0;
      bn = q.b_num;
      n  = 0;
      d  = 0;
      case (q.opcode)
         OP_ADD, OP_SUB: begin
            if (q.opcode == OP_SUB) bn = neg_wrap(bn, ov);
            lhs = mul_wrap(q.a_num, q.b_den, ov);
            rhs = mul_wrap(q.a_den, bn, ov);
            n   = add_wrap(lhs, rhs, ov);
            d   = mul_wrap(q.a_den, q.b_den, ov);
            reduce_frac(n, d, ov);
         end
         OP_MUL: begin
            n = mul_wrap(q.a_num, q.b_num, ov);
            d = mul_wrap(q.a_den, q.b_den, ov);
            reduce_frac(n, d, ov);
         end
         OP_DIV: begin
            n = mul_wrap(q.a_num, q.b_den, ov);
            d = mul_wrap(q.a_den, q.b_num, ov);
            reduce_frac(n, d, ov);
         end
         OP_POW: begin
            n = q.a_num;
            d = q.a_den;
            reduce_frac(n, d, ov);
            n = pow_wrap(n, q.exponent, ov);
            d = pow_wrap(d, q.exponent, ov);
         end
         OP_RED: begin
            n = q.a_num;
            d = q.a_den;
            reduce_frac(n, d, ov);
         end
         OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE: begin
            lhs = mul_wrap(q.a_num, q.b_den, ov);
            rhs = mul_wrap(q.a_den, q.b_num, ov);
            case (q.opcode)
               OP_EQ:   r.truth = (lhs == rhs);
               OP_LT:   r.truth = less_s(lhs, rhs);
               OP_LE:   r.truth = !less_s(rhs, lhs);
               OP_GT:   r.truth = less_s(rhs, lhs);
               default: r.truth = !less_s(lhs, rhs);
            endcase
         end
         default: ;
      endcase
      r.num      = n;
      r.den      = d;
      r.overflow = ov;
      return r;
   endfunction

   // ------------------------------------------------------------ stimulus
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0, 1: return 64'($signed($urandom_range(0, 40)) - 20);
         2:    return 64'($signed($urandom_range(0, 2000000)) - 1000000);
         3:    return {$urandom, $urandom};
         4: begin
            case ($urandom_range(0, 4))
               0: return MIN_WORD;
               1: return MAX_WORD;
               2: return 64'd0;
               3: return 64'd1;
               default: return '1;
            endcase
         end
         default: return {32'($signed($urandom_range(0, 2000)) - 1000), $urandom};
      endcase
   endfunction

   function automatic frac_req_type rand_req();
      frac_req_type q;
      q.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
      q.a_num = rand_word();
      q.a_den = rand_word();
      q.b_num = rand_word();
      q.b_den = rand_word();
      // large exponents are slow, keep them rare
      q.exponent = ($urandom_range(0, 29) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6));
      return q;
   endfunction

   task automatic send_req(input frac_req_type q, input bit typed, input frac_rsp_type known);
      while ($urandom_range(0, 99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.opcode   = q.opcode;
      req_bus.a_num    = q.a_num;
      req_bus.a_den    = q.a_den;
      req_bus.b_num    = q.b_num;
      req_bus.b_den    = q.b_den;
      req_bus.exponent = q.exponent;
      do @(posedge clock); while (!req_bus.ready);
      pending_rsp.push_back(typed ? known : predict_frac(q));
      @(negedge clock);
   endtask

   // ------------------------------------------------------------ response side
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_bus.ready = ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      frac_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%h", rsp_bus.res_num,
                                           rsp_bus.res_den);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.res_num !== want.num || rsp_bus.res_den !== want.den ||
                rsp_bus.truth !== want.truth || rsp_bus.overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%h t%b o%b, got %h/%h t%b o%b",
                           want.num, want.den, want.truth, want.overflow,
                           rsp_bus.res_num, rsp_bus.res_den, rsp_bus.truth,
                           rsp_bus.overflow);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------ main sequence
   table_row_type dir_table[$];

   function automatic table_row_type row(input logic [3:0] op, input logic [63:0] an, ad, bn,
                                         bd, input logic [5:0] e, input bit typed = 0,
                                         input logic [63:0] rn = 0, rd = 0,
                                         input logic t = 0, o = 0);
      table_row_type r;
      r.req   = '{opcode: op, a_num: an, a_den: ad, b_num: bn, b_den: bd, exponent: e};
      r.typed = typed;
      r.rsp   = '{num: rn, den: rd, truth: t, overflow: o};
      return r;
   endfunction

   initial begin
      frac_rsp_type none;
      none = '{num: 0, den: 0, truth: 0, overflow: 0};
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_ADD;
      req_bus.a_num    = 0;
      req_bus.a_den    = 0;
      req_bus.b_num    = 0;
      req_bus.b_den    = 0;
      req_bus.exponent = 0;

      // zero numerator, zero denominator, most negative sign move, unused opcode
      dir_table.push_back(row(OP_RED, 0, 5, 0, 0, 0, 1, 0, 1, 0, 0));
      dir_table.push_back(row(OP_RED, 6, 0, 0, 0, 0, 1, 6, 0, 0, 0));
      dir_table.push_back(row(OP_RED, 4, -8, 0, 0, 0, 1, -1, 2, 0, 0));
      dir_table.push_back(row(OP_RED, MIN_WORD, -1, 0, 0, 0, 1, MIN_WORD, 1, 0, 1));
      dir_table.push_back(row(OP_RED, MAX_WORD, MIN_WORD, 0, 0, 0));
      dir_table.push_back(row(OP_UNUSED, MAX_WORD, 3, 4, 5, 63, 1, 0, 0, 0, 0));
      dir_table.push_back(row(OP_SPARE, '1, '1, '1, '1, '1, 1, 0, 0, 0, 0));
      dir_table.push_back(row(OP_POW, 3, 4, 0, 0, 0, 1, 1, 1, 0, 0));
      dir_table.push_back(row(OP_POW, -1, 1, 0, 0, 63, 1, -1, 1, 0, 0));
      dir_table.push_back(row(OP_POW, 2, 1, 0, 0, 63));
      dir_table.push_back(row(OP_POW, -6, 4, 0, 0, 5));
      dir_table.push_back(row(OP_EQ, 1, 2, 2, 4, 0, 1, 0, 0, 1, 0));
      dir_table.push_back(row(OP_LT, 1, 3, 1, 2, 0, 1, 0, 0, 1, 0));
      dir_table.push_back(row(OP_LE, 1, 2, 1, 2, 0, 1, 0, 0, 1, 0));
      dir_table.push_back(row(OP_GT, 1, 3, 1, 2, 0, 1, 0, 0, 0, 0));
      dir_table.push_back(row(OP_GE, MIN_WORD, MAX_WORD, MAX_WORD, MIN_WORD, 0));
      dir_table.push_back(row(OP_ADD, 1, 2, 1, 3, 0, 1, 5, 6, 0, 0));
      dir_table.push_back(row(OP_ADD, MAX_WORD, 1, MAX_WORD, 1, 0));
      dir_table.push_back(row(OP_SUB, 1, 2, MIN_WORD, 1, 0));
      dir_table.push_back(row(OP_SUB, 3, 4, 1, 4, 0, 1, 1, 2, 0, 0));
      dir_table.push_back(row(OP_MUL, -2, 3, 9, -4, 0));
      dir_table.push_back(row(OP_MUL, MIN_WORD, MIN_WORD, '1, '1, 0));
      dir_table.push_back(row(OP_DIV, 2, 3, 4, 9, 0));
      dir_table.push_back(row(OP_DIV, 5, 7, 0, 1, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      send_idle = 36;
      recv_idle = 71;
      foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].rsp);

      // long response hold-off while requests keep coming
      hold_req = 1'b1;
      send_idle = 0;
      repeat (12) send_req(rand_req(), 0, none);

      // pause until everything has drained
      req_bus.valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            send_idle = 71;
            recv_idle = 36;
         end else if (i == 2 * N_RANDOM / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (i == 0) begin
            send_idle = 36;
            recv_idle = 71;
         end
         send_req(rand_req(), 0, none);
      end
      req_bus.valid = 1'b0;

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
